// ----- sv/msblm_pkg.sv -----
// Shared types and constants for the memory slave bandwidth and latency model.
package msblm_pkg;

    localparam logic [1:0] OP_REQ  = 2'd0;
    localparam logic [1:0] OP_PASS = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] CFG_LATENCY   = 2'd0;
    localparam logic [1:0] CFG_BANDWIDTH = 2'd1;
    localparam logic [1:0] CFG_NODE      = 2'd2;

    localparam logic [47:0] CYCLE_MAX = 48'hFFFF_FFFF_FFFF;

    // Request fields carried without the id.
    typedef struct packed {
        logic        is_read;
        logic [7:0]  req_src;
        logic [7:0]  req_size;
        logic [47:0] req_addr;
    } req_body_t;

endpackage

// ----- sv/msblm_front.sv -----
// Front end: input beat skid queue that decouples accepting from execution.
module msblm_front #(
    parameter int TXN_BITS = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              in_op,
    input  logic [TXN_BITS-1:0]     in_id,
    input  msblm_pkg::req_body_t    in_body,
    output logic                    q_valid,
    input  logic                    q_take,
    output logic [1:0]              q_op,
    output logic [TXN_BITS-1:0]     q_id,
    output msblm_pkg::req_body_t    q_body
);

    logic [1:0]           op_reg [2];
    logic [TXN_BITS-1:0]  id_reg [2];
    msblm_pkg::req_body_t body_reg [2];
    logic [1:0]           cnt_reg;
    logic                 rd_reg;
    logic                 wr_ptr;
    logic                 push;
    logic                 pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign pop      = q_take && (cnt_reg != 2'd0);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_op     = op_reg[rd_reg];
    assign q_id     = id_reg[rd_reg];
    assign q_body   = body_reg[rd_reg];
    assign wr_ptr   = rd_reg ^ cnt_reg[0];

    // Store each accepted beat; the back end ignores opcode 3
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_reg[wr_ptr]   <= in_op;
            id_reg[wr_ptr]   <= in_id;
            body_reg[wr_ptr] <= in_body;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (pop)
                rd_reg <= ~rd_reg;
        end
    end

endmodule

// ----- sv/msblm_back.sv -----
// Back end: pending table, wait FIFO, budget and completion scanner.
module msblm_back #(
    parameter int TXN_BITS    = 6,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [15:0]             cfg_latency,
    input  logic [15:0]             cfg_bandwidth,
    input  logic [7:0]              cfg_node,
    input  logic                    q_valid,
    output logic                    q_take,
    input  logic [1:0]              q_op,
    input  logic [TXN_BITS-1:0]     q_id,
    input  msblm_pkg::req_body_t    q_body,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [TXN_BITS-1:0]     resp_txn_id,
    output logic                    is_data,
    output logic [7:0]              src_ident,
    output logic [7:0]              dest_node,
    output logic [47:0]             resp_addr,
    output logic [7:0]              resp_size,
    output logic [31:0]             latency,
    output logic                    last
);

    localparam int NUM_TXN = 1 << TXN_BITS;
    localparam int QB      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CB      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DRD   = 3'd5;
    localparam logic [2:0] ST_DUP   = 3'd6;

    // Pending table memories
    msblm_pkg::req_body_t pend_mem [NUM_TXN];
    logic [47:0]          issue_mem [NUM_TXN];
    logic [47:0]          due_mem [NUM_TXN];
    logic [NUM_TXN-1:0]   pvalid_reg;

    // Wait FIFO memories
    logic [TXN_BITS-1:0]  wid_mem [QUEUE_DEPTH];
    msblm_pkg::req_body_t wbody_mem [QUEUE_DEPTH];
    logic [47:0]          wissue_mem [QUEUE_DEPTH];
    logic [QB-1:0]        whead_reg;
    logic [CB-1:0]        wcount_reg;

    logic [2:0]           state_reg;
    logic [47:0]          cycle_reg;
    logic [16:0]          used_reg;
    logic [15:0]          dropped_reg;
    logic [TXN_BITS:0]    scan_reg;

    // Registered read ports
    msblm_pkg::req_body_t prd_body_reg;
    logic [47:0]          prd_issue_reg;
    logic [47:0]          prd_due_reg;
    logic                 prd_valid_reg;
    logic [TXN_BITS-1:0]  prd_id_reg;
    logic [TXN_BITS-1:0]  wrd_id_reg;
    msblm_pkg::req_body_t wrd_body_reg;
    logic [47:0]          wrd_issue_reg;

    // Held response (one ahead so last can be known)
    logic                 hold_reg;
    logic [TXN_BITS-1:0]  h_id_reg;
    msblm_pkg::req_body_t h_body_reg;
    logic [31:0]          h_lat_reg;

    // Output beat register
    logic                 ov_reg;
    logic [TXN_BITS-1:0]  o_id_reg;
    msblm_pkg::req_body_t o_body_reg;
    logic [31:0]          o_lat_reg;

    logic [16:0]          fit_sum;
    logic                 fits_req;
    logic                 fits_wait;
    logic [48:0]          due_sum;
    logic [47:0]          due_now;
    logic [47:0]          lat_diff;
    logic [31:0]          lat_sat;
    logic                 due_hit;
    logic [31:0]          wsum;
    logic [QB-1:0]        wtail;
    logic                 out_free;
    logic                 scan_done;
    logic                 emit;
    logic                 emit_last;

    assign fit_sum   = used_reg + {9'd0, q_body.req_size};
    assign fits_req  = fit_sum <= {1'b0, cfg_bandwidth};
    assign fits_wait = (used_reg + {9'd0, wrd_body_reg.req_size}) <= {1'b0, cfg_bandwidth};
    assign due_sum   = {1'b0, cycle_reg} + {33'd0, cfg_latency};
    assign due_now   = due_sum[48] ? msblm_pkg::CYCLE_MAX : due_sum[47:0];
    assign lat_diff  = (cycle_reg >= prd_issue_reg) ? cycle_reg - prd_issue_reg : 48'd0;
    assign lat_sat   = (lat_diff[47:32] != 16'd0) ? 32'hFFFF_FFFF : lat_diff[31:0];
    assign due_hit   = prd_valid_reg && (prd_due_reg <= cycle_reg);
    assign wsum      = 32'(whead_reg) + 32'(wcount_reg);
    assign wtail     = QB'((wsum >= QUEUE_DEPTH) ? wsum - QUEUE_DEPTH : wsum);
    assign out_free  = !ov_reg || !out_stall;
    assign scan_done = scan_reg[TXN_BITS];
    assign q_take    = (state_reg == ST_IDLE) && q_valid;
    assign emit_last = (state_reg == ST_EMIT);
    assign emit      = hold_reg && out_free
                       && (emit_last || (state_reg == ST_CHECK && due_hit));

    // Output beat
    assign resp_txn_id = o_id_reg;
    assign is_data     = o_body_reg.is_read;
    assign src_ident   = cfg_node;
    assign dest_node   = o_body_reg.req_src;
    assign resp_addr   = o_body_reg.req_addr;
    assign resp_size   = o_body_reg.is_read ? o_body_reg.req_size : 8'd0;
    assign latency     = o_lat_reg;
    assign out_valid   = ov_reg;

    logic                 pw_en;
    logic [TXN_BITS-1:0]  pw_id;
    msblm_pkg::req_body_t pw_body;
    logic [47:0]          pw_issue;

    // Choose the pending table write
    always_comb
    begin
        pw_en    = 1'b0;
        pw_id    = q_id;
        pw_body  = q_body;
        pw_issue = cycle_reg;
        if (q_take && q_op == msblm_pkg::OP_REQ && fits_req && !pvalid_reg[q_id])
            pw_en = 1'b1;
        else if (state_reg == ST_DUP && !pvalid_reg[wrd_id_reg])
        begin
            pw_en    = 1'b1;
            pw_id    = wrd_id_reg;
            pw_body  = wrd_body_reg;
            pw_issue = wrd_issue_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            pend_mem[pw_id]  <= pw_body;
            issue_mem[pw_id] <= pw_issue;
            due_mem[pw_id]   <= due_now;
        end
        if (q_take && q_op == msblm_pkg::OP_REQ && !fits_req
            && 32'(wcount_reg) < QUEUE_DEPTH)
        begin
            wid_mem[wtail]    <= q_id;
            wbody_mem[wtail]  <= q_body;
            wissue_mem[wtail] <= cycle_reg;
        end
        // Hold the scanned entry while its check waits on the output
        if (state_reg == ST_SCAN)
        begin
            prd_body_reg  <= pend_mem[scan_reg[TXN_BITS-1:0]];
            prd_issue_reg <= issue_mem[scan_reg[TXN_BITS-1:0]];
            prd_due_reg   <= due_mem[scan_reg[TXN_BITS-1:0]];
        end
        wrd_id_reg    <= wid_mem[whead_reg];
        wrd_body_reg  <= wbody_mem[whead_reg];
        wrd_issue_reg <= wissue_mem[whead_reg];
    end

    // Load the output beat from the held response
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg     <= 1'b0;
            last       <= 1'b0;
            o_id_reg   <= '0;
            o_body_reg <= '0;
            o_lat_reg  <= '0;
        end
        else if (emit)
        begin
            ov_reg     <= 1'b1;
            last       <= emit_last;
            o_id_reg   <= h_id_reg;
            o_body_reg <= h_body_reg;
            o_lat_reg  <= h_lat_reg;
        end
        else if (!out_stall)
            ov_reg <= 1'b0;
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cycle_reg     <= '0;
            used_reg      <= '0;
            dropped_reg   <= '0;
            pvalid_reg    <= '0;
            whead_reg     <= '0;
            wcount_reg    <= '0;
            scan_reg      <= '0;
            hold_reg      <= 1'b0;
            prd_valid_reg <= 1'b0;
            prd_id_reg    <= '0;
            h_id_reg      <= '0;
            h_body_reg    <= '0;
            h_lat_reg     <= '0;
        end
        else
        begin
            if (pw_en)
                pvalid_reg[pw_id] <= 1'b1;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_take)
                    begin
                        unique case (q_op)
                            msblm_pkg::OP_REQ:
                            begin
                                if (fits_req)
                                    used_reg <= fit_sum;
                                else if (32'(wcount_reg) < QUEUE_DEPTH)
                                    wcount_reg <= wcount_reg + 1'b1;
                                else if (dropped_reg != 16'hFFFF)
                                    dropped_reg <= dropped_reg + 1'b1;
                            end
                            msblm_pkg::OP_PASS:
                            begin
                                scan_reg  <= '0;
                                hold_reg  <= 1'b0;
                                state_reg <= ST_SCAN;
                            end
                            msblm_pkg::OP_TICK:
                            begin
                                if (cycle_reg != msblm_pkg::CYCLE_MAX)
                                    cycle_reg <= cycle_reg + 1'b1;
                                used_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    // Read one entry; its data lands next cycle
                    prd_valid_reg <= pvalid_reg[scan_reg[TXN_BITS-1:0]];
                    prd_id_reg    <= scan_reg[TXN_BITS-1:0];
                    scan_reg      <= scan_reg + 1'b1;
                    state_reg     <= scan_done ? ST_EMIT : ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (!due_hit)
                        state_reg <= ST_SCAN;
                    else if (!hold_reg || out_free)
                    begin
                        // Held beat moves to the output; hold the new one
                        pvalid_reg[prd_id_reg] <= 1'b0;
                        hold_reg   <= 1'b1;
                        h_id_reg   <= prd_id_reg;
                        h_body_reg <= prd_body_reg;
                        h_lat_reg  <= lat_sat;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_EMIT:
                begin
                    if (!hold_reg)
                        state_reg <= ST_DRAIN;
                    else if (out_free)
                    begin
                        hold_reg  <= 1'b0;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                    state_reg <= (wcount_reg != '0) ? ST_DRD : ST_IDLE;
                ST_DRD:
                begin
                    if (fits_wait)
                    begin
                        used_reg   <= used_reg + {9'd0, wrd_body_reg.req_size};
                        state_reg  <= ST_DUP;
                    end
                    else
                        state_reg <= ST_IDLE;
                end
                ST_DUP:
                begin
                    whead_reg  <= (32'(whead_reg) == QUEUE_DEPTH - 1) ? '0
                                                                      : whead_reg + 1'b1;
                    wcount_reg <= wcount_reg - 1'b1;
                    state_reg  <= ST_DRAIN;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/memory_slave_bandwidth_latency_model.sv -----
// Memory slave node: budgeted admission, fixed latency, completion passes in id order.
// A request, tick or unused-opcode beat is handled in the back end's idle state; a
// completion pass scans the pending table one entry at a time through the scan and
// check states, held while the response channel stalls, and then drains the wait FIFO,
// admitting entries in order while they fit the budget. A two-beat input queue, a held
// response and an output beat register let each side stall on its own.
module memory_slave_bandwidth_latency_model #(
    parameter int TXN_BITS    = 6,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          opcode,
    input  logic [TXN_BITS-1:0] txn_id,
    input  logic                is_read,
    input  logic [47:0]         req_addr,
    input  logic [7:0]          req_size,
    input  logic [7:0]          req_src,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [TXN_BITS-1:0] resp_txn_id,
    output logic                is_data,
    output logic [7:0]          src_ident,
    output logic [7:0]          dest_node,
    output logic [47:0]         resp_addr,
    output logic [7:0]          resp_size,
    output logic [31:0]         latency,
    output logic                last
);

    logic [15:0]          lat_reg;
    logic [15:0]          bw_reg;
    logic [7:0]           node_reg;
    msblm_pkg::req_body_t in_body;
    msblm_pkg::req_body_t q_body;
    logic                 q_valid;
    logic                 q_take;
    logic [1:0]           q_op;
    logic [TXN_BITS-1:0]  q_id;

    assign in_body = '{is_read: is_read, req_src: req_src,
                       req_size: req_size, req_addr: req_addr};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg  <= 16'd100;
            bw_reg   <= 16'd64;
            node_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                msblm_pkg::CFG_LATENCY:   lat_reg  <= cfg_data;
                msblm_pkg::CFG_BANDWIDTH: bw_reg   <= cfg_data;
                msblm_pkg::CFG_NODE:      node_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    msblm_front #(.TXN_BITS(TXN_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .in_op(opcode), .in_id(txn_id), .in_body(in_body),
        .q_valid(q_valid), .q_take(q_take),
        .q_op(q_op), .q_id(q_id), .q_body(q_body)
    );

    msblm_back #(.TXN_BITS(TXN_BITS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cfg_latency(lat_reg), .cfg_bandwidth(bw_reg), .cfg_node(node_reg),
        .q_valid(q_valid), .q_take(q_take),
        .q_op(q_op), .q_id(q_id), .q_body(q_body),
        .out_valid(out_valid), .out_stall(out_stall),
        .resp_txn_id(resp_txn_id), .is_data(is_data), .src_ident(src_ident),
        .dest_node(dest_node), .resp_addr(resp_addr), .resp_size(resp_size),
        .latency(latency), .last(last)
    );

endmodule
